FILE: rtl/hhcrc_pkg.sv
// Package: shared constants, types and the CRC byte step of the frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package hhcrc_pkg;

  localparam int MAX_FRAME    = 128;
  localparam int POS_LIMIT    = 128;
  localparam int LEN_CAP      = (MAX_FRAME > POS_LIMIT) ? POS_LIMIT : MAX_FRAME;
  localparam int LEN_MIN      = 3;

  localparam int BYTE_W       = 8;
  localparam int POS_W        = 7;
  localparam int LEN_W        = 8;
  localparam int CRC_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int OUT_DATA_W   = 16;

  localparam logic [CRC_W-1:0]  CRC_POLY        = 16'h8408;
  localparam logic [LEN_W-1:0]  LEN_RESET       = 8'd32;
  localparam logic [BYTE_W-1:0] HEADER_RESET    = 8'hA5;
  localparam logic [CRC_W-1:0]  SEED_RESET      = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_VALUE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED     = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic [POS_W-1:0]  byte_position;
    logic              frame_end;
    logic              frame_good;
  } hhcrc_res_t;

  // One byte of the reflected CRC-16 (same result as the usual 256-entry table).
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                               input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
    for (int b = 0; b < BYTE_W; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/hhcrc_core.sv
// Frame tracker: configuration registers, header hunt, position count and CRC check.
`timescale 1ns / 1ps
`default_nettype none
module hhcrc_core
  import hhcrc_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_wr_en,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire                   take,
  input  wire [BYTE_W-1:0]      rx_byte,
  output logic                  push,
  output hhcrc_res_t            res
);

  logic [LEN_W-1:0]  frame_length_r;
  logic [BYTE_W-1:0] header_value_r;
  logic [CRC_W-1:0]  crc_seed_r;

  logic              in_frame_r, in_frame_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic              low_match_r, low_match_nxt;

  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  pos_inc;
  logic              is_last;
  logic              is_low;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r <= LEN_RESET;
      header_value_r <= HEADER_RESET;
      crc_seed_r     <= SEED_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FRAME_LENGTH: frame_length_r <= cfg_wdata[LEN_W-1:0];
        CFG_HEADER_VALUE: header_value_r <= cfg_wdata[BYTE_W-1:0];
        CFG_CRC_SEED:     crc_seed_r     <= cfg_wdata[CRC_W-1:0];
        default: ;
      endcase
    end
  end

  // Lengths out of range are clamped to the usable window.
  always_comb begin
    if (frame_length_r > LEN_W'(LEN_CAP)) begin
      len = LEN_W'(LEN_CAP);
    end else if (frame_length_r < LEN_W'(LEN_MIN)) begin
      len = LEN_W'(LEN_MIN);
    end else begin
      len = frame_length_r;
    end
  end

  assign pos_inc = {1'b0, pos_r} + LEN_W'(1);
  assign is_last = (pos_inc >= len);
  assign is_low  = ((pos_inc + LEN_W'(1)) == len);

  always_comb begin
    in_frame_nxt  = in_frame_r;
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    low_match_nxt = low_match_r;
    push          = 1'b0;
    res.frame_byte    = rx_byte;
    res.byte_position = pos_r;
    res.frame_end     = 1'b0;
    res.frame_good    = 1'b0;
    if (take) begin
      if (!in_frame_r) begin
        if (rx_byte == header_value_r) begin
          push              = 1'b1;
          in_frame_nxt      = 1'b1;
          crc_nxt           = crc_byte(crc_seed_r, rx_byte);
          low_match_nxt     = 1'b0;
          pos_nxt           = POS_W'(1);
          res.byte_position = '0;
        end
      end else begin
        push = 1'b1;
        if (is_last) begin
          res.frame_end  = 1'b1;
          res.frame_good = low_match_r && (rx_byte == crc_r[CRC_W-1:BYTE_W]);
          in_frame_nxt   = 1'b0;
          pos_nxt        = '0;
          crc_nxt        = crc_seed_r;
          low_match_nxt  = 1'b0;
        end else if (is_low) begin
          low_match_nxt = (rx_byte == crc_r[BYTE_W-1:0]);
          pos_nxt       = pos_inc[POS_W-1:0];
        end else begin
          crc_nxt = crc_byte(crc_r, rx_byte);
          pos_nxt = pos_inc[POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      pos_r       <= '0;
      crc_r       <= SEED_RESET;
      low_match_r <= 1'b0;
    end else begin
      in_frame_r  <= in_frame_nxt;
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      low_match_r <= low_match_nxt;
    end
  end

  // The position counter is nonzero exactly while a frame is open.
  a_pos_tracks_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r == (pos_r != '0))
    else $error("position count out of step with frame state");

  // A transfer taken while hunting can only open a frame at position zero.
  a_header_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !in_frame_r) |-> (res.byte_position == '0 && !res.frame_end))
    else $error("frame start not at position zero");

  // Closing a frame returns the tracker to hunting on the next cycle.
  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.frame_end) |=> !in_frame_r)
    else $error("frame still open after last byte");

endmodule
`default_nettype wire

FILE: rtl/hhcrc_out_buf.sv
// Output register with a skid stage between the frame tracker and the result stream.
`timescale 1ns / 1ps
`default_nettype none
module hhcrc_out_buf
  import hhcrc_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         push,
  input  hhcrc_res_t  push_res,
  output logic        can_take,
  output logic        out_vld,
  input  wire         out_rdy,
  output hhcrc_res_t  out_res
);

  logic       main_vld_r;
  hhcrc_res_t main_r;
  logic       skid_vld_r;
  hhcrc_res_t skid_r;
  logic       pop;

  assign pop      = main_vld_r && out_rdy;
  assign can_take = !skid_vld_r;
  assign out_vld  = main_vld_r;
  assign out_res  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!main_vld_r || pop) begin
      main_vld_r <= skid_vld_r || push;
      skid_vld_r <= 1'b0;
    end else if (push) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_vld_r || pop) begin
      main_r <= skid_vld_r ? skid_r : push_res;
    end else if (push) begin
      skid_r <= push_res;
    end
  end

  // The skid stage only fills behind a held output register.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> main_vld_r)
    else $error("skid stage full while output register empty");

  // A stalled result that was joined by another stays put.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (main_vld_r && !out_rdy && push) |=> (skid_vld_r && $stable(main_r)))
    else $error("stalled result lost or overwritten");

endmodule
`default_nettype wire

FILE: rtl/header_hunt_crc16_frame_receiver_top.sv
// Top level of the header-hunting frame receiver with CRC-16/MCRF4XX check.
//
// Channel  | Direction | Handshake             | Contents
// in_      | slave     | in_tvalid/in_tready   | tdata[7:0] rx_byte
// out_     | master    | out_tvalid/out_tready | tdata frame_byte, byte_position;
//          |           |                       | tlast frame_end; tuser frame_good
// cfg_     | write     | cfg_wr_en             | cfg_index, cfg_wdata
//
// One byte is accepted per cycle while in_tready is high; its result is registered.
// The CRC byte step and position compare sit between the input and the output register.
// A two-entry output stage (register plus skid) keeps accepting while a result waits.
// in_tready falls only when both entries are full; bytes dropped while hunting use no entry.
// Synchronous active-low reset returns to hunting with the default configuration.
`timescale 1ns / 1ps
`default_nettype none
module header_hunt_crc16_frame_receiver_top
  import hhcrc_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_wr_en,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire [BYTE_W-1:0]      in_tdata,   // [7:0] rx_byte
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] frame_byte, [14:8] byte_position, [15] zero
  output logic                  out_tlast,  // frame_end
  output logic                  out_tuser   // [0] frame_good
);

  logic       take;
  logic       push;
  hhcrc_res_t push_res;
  hhcrc_res_t out_res;

  assign take = in_tvalid && in_tready;

  hhcrc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .rx_byte   (in_tdata),
    .push      (push),
    .res       (push_res)
  );

  hhcrc_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_res (push_res),
    .can_take (in_tready),
    .out_vld  (out_tvalid),
    .out_rdy  (out_tready),
    .out_res  (out_res)
  );

  assign out_tdata = {1'b0, out_res.byte_position, out_res.frame_byte};
  assign out_tlast = out_res.frame_end;
  assign out_tuser = out_res.frame_good;

endmodule
`default_nettype wire
